// ===== src/scpf_pkg.sv =====
package scpf_pkg;

    localparam int POS_W  = 32;
    localparam int RAD_W  = 24;
    localparam int SEP_W  = POS_W + 1;
    localparam int MAG_W  = POS_W;
    localparam int BOX_W  = 31;
    localparam int K_W    = 32;
    localparam int SUMR_W = RAD_W + 1;
    localparam int AX_W   = 25;
    localparam int SQ_W   = 2 * AX_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int RT_N   = (D2_W + 1) / 2;
    localparam int D_W    = RT_N;
    localparam int OV_W   = SUMR_W;
    localparam int M_W    = 58;
    localparam int M_LO_W = 29;
    localparam int PP_W   = M_LO_W + AX_W;
    localparam int N_W    = M_W + AX_W;
    localparam int Q_W    = 32;
    localparam int CFG_W  = 32;
    localparam int ADDR_W = 3;
    localparam int IN_W   = 176;
    localparam int OUT_W  = 64;

    localparam logic [M_W-1:0] MAG_CAP  = M_W'(1) << 57;
    localparam logic [Q_W-1:0] LIM_POS  = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] LIM_NEG  = 32'h8000_0000;

    typedef enum logic [ADDR_W-1:0] {
        REG_FORCE_LAW,
        REG_STIFF_HARM,
        REG_STIFF_HERTZ,
        REG_PERIODIC,
        REG_BOX_W,
        REG_BOX_H
    } cfg_reg_t;

    typedef enum logic {
        LAW_HARMONIC,
        LAW_HERTZIAN
    } force_law_t;

    typedef struct packed {
        logic [Q_W-1:0] force_val;
        logic           sat;
    } emit_t;

    // Sign is opposite to the separation; clip to the signed 32-bit range.
    function automatic emit_t emit_force(input logic sep_pos, input logic big,
                                         input logic [Q_W-1:0] q);
        emit_t r;
        r.sat = 1'b0;
        if (sep_pos)
        begin
            if (big || q > LIM_NEG)
            begin
                r.force_val = LIM_NEG;
                r.sat       = 1'b1;
            end
            else
            begin
                r.force_val = Q_W'(0) - q;
            end
        end
        else
        begin
            if (big || q[Q_W-1])
            begin
                r.force_val = LIM_POS;
                r.sat       = 1'b1;
            end
            else
            begin
                r.force_val = q;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/soft_contact_pair_force.sv =====
// Contact force on disc i from disc j in signed fixed point with FRAC_BITS fractional
// bits. Each input word carries both centres and radii; each output word carries the
// saturated x and y force plus coincident and saturated flags. One pair is accepted
// per clock while the pipeline is not held. The pipeline contains two 32-step
// restoring remainder chains for the periodic wrap, a 26-step distance square root,
// the Hertzian square root and a 32-step quotient chain that scales the magnitude
// onto each axis. When the output word is not taken, the whole pipeline holds.
// Configuration should be written only while the pipeline is empty.
module soft_contact_pair_force
    import scpf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_i_x, pos_i_y, pos_j_x, pos_j_y, radius_i_in, radius_j_in
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // force_x, force_y
    output logic [OUT_W-1:0]  m_axis_tdata,
    // coincident, saturated
    output logic [1:0]        m_axis_tuser,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int HV_W  = OV_W + FRAC_BITS;
    localparam int HR_N  = (HV_W + 1) / 2;
    localparam int P_W   = OV_W + HR_N - FRAC_BITS;
    localparam int HM_W  = K_W + OV_W - FRAC_BITS;
    localparam int KP_W  = K_W + P_W;
    localparam int KPX_W = (KP_W > 65) ? KP_W : 65;

    localparam int DIV_LO = 1;
    localparam int DIV_HI = DIV_LO + MAG_W - 1;
    localparam int ST_B1  = DIV_HI + 1;
    localparam int ST_B2  = ST_B1 + 1;
    localparam int ST_SQ  = ST_B2 + 1;
    localparam int ST_SUM = ST_SQ + 1;
    localparam int RT_LO  = ST_SUM + 1;
    localparam int RT_HI  = RT_LO + RT_N - 1;
    localparam int ST_OV  = RT_HI + 1;
    localparam int HR_LO  = ST_OV + 1;
    localparam int HR_HI  = HR_LO + HR_N - 1;
    localparam int ST_PM  = HR_HI + 1;
    localparam int ST_KP  = ST_PM + 1;
    localparam int ST_MS  = ST_KP + 1;
    localparam int ST_PP  = ST_MS + 1;
    localparam int ST_PA  = ST_PP + 1;
    localparam int ST_QI  = ST_PA + 1;
    localparam int Q_LO   = ST_QI + 1;
    localparam int Q_HI   = Q_LO + Q_W - 1;
    localparam int ST_EM  = Q_HI + 1;
    localparam int N_STAGE = ST_EM + 1;

    typedef struct packed {
        logic                    neg_x;
        logic                    neg_y;
        logic [SEP_W-2:0]        mag_x;
        logic [SEP_W-2:0]        mag_y;
        logic [BOX_W-1:0]        rem_x;
        logic [BOX_W-1:0]        rem_y;
        logic [SUMR_W-1:0]       sumr;
        logic [MAG_W-1:0]        ax;
        logic [MAG_W-1:0]        ay;
        logic                    pos_x;
        logic                    pos_y;
        logic                    coinc;
        logic                    zero;
        logic [SQ_W-1:0]         sq_x;
        logic [SQ_W-1:0]         sq_y;
        logic [D2_W-1:0]         rt_v;
        logic [D2_W-1:0]         rt_r;
        logic [D_W-1:0]          d_len;
        logic [OV_W-1:0]         ov;
        logic [HV_W-1:0]         hv;
        logic [HV_W-1:0]         hr;
        logic [HM_W-1:0]         hm;
        logic [P_W-1:0]          p;
        logic [KP_W-1:0]         kp;
        logic [M_W-1:0]          m;
        logic [PP_W-1:0]         px_lo;
        logic [PP_W-1:0]         px_hi;
        logic [PP_W-1:0]         py_lo;
        logic [PP_W-1:0]         py_hi;
        logic [N_W-1:0]          nx;
        logic [N_W-1:0]          ny;
        logic                    big_x;
        logic                    big_y;
        logic [D_W-1:0]          qr_x;
        logic [D_W-1:0]          qr_y;
        logic [Q_W-1:0]          q_x;
        logic [Q_W-1:0]          q_y;
        logic [Q_W-1:0]          fx;
        logic [Q_W-1:0]          fy;
        logic                    sat;
    } item_t;

    force_law_t       force_law_reg;
    logic [K_W-1:0]   stiff_harm_reg;
    logic [K_W-1:0]   stiff_hertz_reg;
    logic             periodic_reg;
    logic [BOX_W-1:0] box_w_reg;
    logic [BOX_W-1:0] box_h_reg;

    item_t            pipe_reg   [N_STAGE];
    item_t            pipe_next  [N_STAGE];
    logic [N_STAGE-1:0] pipe_valid_reg;
    logic             stage_en;

    logic wrap_x;
    logic wrap_y;

    assign stage_en      = !pipe_valid_reg[ST_EM] || m_axis_tready;
    assign s_axis_tready = stage_en;
    assign wrap_x        = periodic_reg && (box_w_reg != '0);
    assign wrap_y        = periodic_reg && (box_h_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_law_reg   <= LAW_HARMONIC;
            stiff_harm_reg  <= K_W'(65536);
            stiff_hertz_reg <= K_W'(65536);
            periodic_reg    <= 1'b1;
            box_w_reg       <= BOX_W'(6553600);
            box_h_reg       <= BOX_W'(6553600);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_FORCE_LAW:   force_law_reg   <= force_law_t'(cfg_wdata[0]);
                REG_STIFF_HARM:  stiff_harm_reg  <= cfg_wdata;
                REG_STIFF_HERTZ: stiff_hertz_reg <= cfg_wdata;
                REG_PERIODIC:    periodic_reg    <= cfg_wdata[0];
                REG_BOX_W:       box_w_reg       <= cfg_wdata[BOX_W-1:0];
                REG_BOX_H:       box_h_reg       <= cfg_wdata[BOX_W-1:0];
                default:         ;
            endcase
        end
    end

    // Entry stage: exact separation j - i, its magnitude and the sum of the radii.
    always_comb
    begin
        logic [SEP_W-1:0] dx;
        logic [SEP_W-1:0] dy;
        pipe_next[0] = '0;
        dx = {s_axis_tdata[95], s_axis_tdata[95:64]} - {s_axis_tdata[31], s_axis_tdata[31:0]};
        dy = {s_axis_tdata[127], s_axis_tdata[127:96]}
           - {s_axis_tdata[63], s_axis_tdata[63:32]};
        pipe_next[0].neg_x = dx[SEP_W-1];
        pipe_next[0].neg_y = dy[SEP_W-1];
        pipe_next[0].mag_x = dx[SEP_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
        pipe_next[0].mag_y = dy[SEP_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
        pipe_next[0].sumr  = SUMR_W'(s_axis_tdata[151:128]) + SUMR_W'(s_axis_tdata[175:152]);
    end

    for (genvar i = 1; i < N_STAGE; i++)
    begin : g_stage
        item_t pv;
        item_t sd;
        assign pv = pipe_reg[i-1];
        assign pipe_next[i] = sd;

        if (i >= DIV_LO && i <= DIV_HI)
        begin : g_div
            // One remainder bit per stage, most significant bit first.
            always_comb
            begin
                logic [BOX_W:0] tx;
                logic [BOX_W:0] ty;
                sd = pv;
                tx = {pv.rem_x, pv.mag_x[MAG_W-1-(i-DIV_LO)]};
                ty = {pv.rem_y, pv.mag_y[MAG_W-1-(i-DIV_LO)]};
                if (tx >= {1'b0, box_w_reg})
                begin
                    tx = tx - {1'b0, box_w_reg};
                end
                if (ty >= {1'b0, box_h_reg})
                begin
                    ty = ty - {1'b0, box_h_reg};
                end
                sd.rem_x = tx[BOX_W-1:0];
                sd.rem_y = ty[BOX_W-1:0];
            end
        end
        else if (i == ST_B1)
        begin : g_b1
            // Floor remainder for a negative separation.
            always_comb
            begin
                sd = pv;
                if (pv.neg_x && pv.rem_x != '0)
                begin
                    sd.rem_x = box_w_reg - pv.rem_x;
                end
                if (pv.neg_y && pv.rem_y != '0)
                begin
                    sd.rem_y = box_h_reg - pv.rem_y;
                end
            end
        end
        else if (i == ST_B2)
        begin : g_b2
            // Fold to the nearest image when wrapping; exactly half a box stays positive.
            always_comb
            begin
                sd = pv;
                if (wrap_x)
                begin
                    if ({pv.rem_x, 1'b0} > {1'b0, box_w_reg})
                    begin
                        sd.ax    = MAG_W'(box_w_reg - pv.rem_x);
                        sd.pos_x = 1'b0;
                    end
                    else
                    begin
                        sd.ax    = MAG_W'(pv.rem_x);
                        sd.pos_x = (pv.rem_x != '0);
                    end
                end
                else
                begin
                    sd.ax    = pv.mag_x;
                    sd.pos_x = !pv.neg_x && (pv.mag_x != '0);
                end
                if (wrap_y)
                begin
                    if ({pv.rem_y, 1'b0} > {1'b0, box_h_reg})
                    begin
                        sd.ay    = MAG_W'(box_h_reg - pv.rem_y);
                        sd.pos_y = 1'b0;
                    end
                    else
                    begin
                        sd.ay    = MAG_W'(pv.rem_y);
                        sd.pos_y = (pv.rem_y != '0);
                    end
                end
                else
                begin
                    sd.ay    = pv.mag_y;
                    sd.pos_y = !pv.neg_y && (pv.mag_y != '0);
                end
                sd.coinc = (sd.ax == '0) && (sd.ay == '0);
                sd.zero  = sd.coinc || (sd.ax[MAG_W-1:AX_W] != '0)
                         || (sd.ay[MAG_W-1:AX_W] != '0);
            end
        end
        else if (i == ST_SQ)
        begin : g_sq
            always_comb
            begin
                sd = pv;
                sd.sq_x = SQ_W'(pv.ax[AX_W-1:0]) * SQ_W'(pv.ax[AX_W-1:0]);
                sd.sq_y = SQ_W'(pv.ay[AX_W-1:0]) * SQ_W'(pv.ay[AX_W-1:0]);
            end
        end
        else if (i == ST_SUM)
        begin : g_sum
            always_comb
            begin
                sd = pv;
                sd.rt_v = D2_W'(pv.sq_x) + D2_W'(pv.sq_y);
                sd.rt_r = '0;
            end
        end
        else if (i >= RT_LO && i <= RT_HI)
        begin : g_rt
            always_comb
            begin
                logic [D2_W-1:0] bt;
                logic [D2_W-1:0] tr;
                sd = pv;
                bt = D2_W'(1) << (2 * (RT_N - 1 - (i - RT_LO)));
                tr = pv.rt_r + bt;
                if (pv.rt_v >= tr)
                begin
                    sd.rt_v = pv.rt_v - tr;
                    sd.rt_r = (pv.rt_r >> 1) + bt;
                end
                else
                begin
                    sd.rt_r = pv.rt_r >> 1;
                end
            end
        end
        else if (i == ST_OV)
        begin : g_ov
            always_comb
            begin
                logic [D_W-1:0] diff;
                sd = pv;
                sd.d_len = pv.rt_r[D_W-1:0];
                diff     = D_W'(pv.sumr) - pv.rt_r[D_W-1:0];
                if (pv.rt_r[D_W-1:0] >= D_W'(pv.sumr))
                begin
                    sd.zero = 1'b1;
                end
                sd.ov = diff[OV_W-1:0];
                sd.hv = {diff[OV_W-1:0], FRAC_BITS'(0)};
                sd.hr = '0;
            end
        end
        else if (i >= HR_LO && i <= HR_HI)
        begin : g_hr
            always_comb
            begin
                logic [HV_W-1:0] bt;
                logic [HV_W-1:0] tr;
                sd = pv;
                bt = HV_W'(1) << (2 * (HR_N - 1 - (i - HR_LO)));
                tr = pv.hr + bt;
                if (pv.hv >= tr)
                begin
                    sd.hv = pv.hv - tr;
                    sd.hr = (pv.hr >> 1) + bt;
                end
                else
                begin
                    sd.hr = pv.hr >> 1;
                end
            end
        end
        else if (i == ST_PM)
        begin : g_pm
            always_comb
            begin
                logic [OV_W+HR_N-1:0] os;
                logic [K_W+OV_W-1:0]  ko;
                sd = pv;
                os = (OV_W+HR_N)'(pv.ov) * (OV_W+HR_N)'(pv.hr[HR_N-1:0]);
                ko = (K_W+OV_W)'(stiff_harm_reg) * (K_W+OV_W)'(pv.ov);
                sd.p  = os[OV_W+HR_N-1:FRAC_BITS];
                sd.hm = ko[K_W+OV_W-1:FRAC_BITS];
            end
        end
        else if (i == ST_KP)
        begin : g_kp
            always_comb
            begin
                sd = pv;
                sd.kp = KP_W'(stiff_hertz_reg) * KP_W'(pv.p);
            end
        end
        else if (i == ST_MS)
        begin : g_ms
            always_comb
            begin
                logic [KPX_W-1:0] kpx;
                logic [KPX_W-1:0] kps;
                sd  = pv;
                kpx = KPX_W'(pv.kp);
                kps = kpx >> FRAC_BITS;
                if (force_law_reg == LAW_HERTZIAN)
                begin
                    // A product past 64 bits is capped as well.
                    if (kpx >= (KPX_W'(1) << 64) || kps > KPX_W'(MAG_CAP))
                    begin
                        sd.m = MAG_CAP;
                    end
                    else
                    begin
                        sd.m = kps[M_W-1:0];
                    end
                end
                else
                begin
                    sd.m = (M_W'(pv.hm) > MAG_CAP) ? MAG_CAP : M_W'(pv.hm);
                end
            end
        end
        else if (i == ST_PP)
        begin : g_pp
            always_comb
            begin
                sd = pv;
                sd.px_lo = PP_W'(pv.m[M_LO_W-1:0]) * PP_W'(pv.ax[AX_W-1:0]);
                sd.px_hi = PP_W'(pv.m[M_W-1:M_LO_W]) * PP_W'(pv.ax[AX_W-1:0]);
                sd.py_lo = PP_W'(pv.m[M_LO_W-1:0]) * PP_W'(pv.ay[AX_W-1:0]);
                sd.py_hi = PP_W'(pv.m[M_W-1:M_LO_W]) * PP_W'(pv.ay[AX_W-1:0]);
            end
        end
        else if (i == ST_PA)
        begin : g_pa
            always_comb
            begin
                sd = pv;
                sd.nx = (N_W'(pv.px_hi) << M_LO_W) + N_W'(pv.px_lo);
                sd.ny = (N_W'(pv.py_hi) << M_LO_W) + N_W'(pv.py_lo);
            end
        end
        else if (i == ST_QI)
        begin : g_qi
            // A quotient of 2^32 or more saturates; otherwise the top part is below d.
            always_comb
            begin
                sd = pv;
                sd.big_x = pv.nx[N_W-1:Q_W] >= (N_W-Q_W)'(pv.d_len);
                sd.big_y = pv.ny[N_W-1:Q_W] >= (N_W-Q_W)'(pv.d_len);
                sd.qr_x  = pv.nx[Q_W+D_W-1:Q_W];
                sd.qr_y  = pv.ny[Q_W+D_W-1:Q_W];
                sd.q_x   = '0;
                sd.q_y   = '0;
            end
        end
        else if (i >= Q_LO && i <= Q_HI)
        begin : g_q
            always_comb
            begin
                logic [D_W:0] tx;
                logic [D_W:0] ty;
                logic         bx;
                logic         by;
                sd = pv;
                tx = {pv.qr_x, pv.nx[Q_W-1-(i-Q_LO)]};
                ty = {pv.qr_y, pv.ny[Q_W-1-(i-Q_LO)]};
                bx = (tx >= {1'b0, pv.d_len});
                by = (ty >= {1'b0, pv.d_len});
                if (bx)
                begin
                    tx = tx - {1'b0, pv.d_len};
                end
                if (by)
                begin
                    ty = ty - {1'b0, pv.d_len};
                end
                sd.qr_x = tx[D_W-1:0];
                sd.qr_y = ty[D_W-1:0];
                sd.q_x  = {pv.q_x[Q_W-2:0], bx};
                sd.q_y  = {pv.q_y[Q_W-2:0], by};
            end
        end
        else
        begin : g_em
            always_comb
            begin
                emit_t ex;
                emit_t ey;
                sd = pv;
                ex = emit_force(pv.pos_x, pv.big_x, pv.q_x);
                ey = emit_force(pv.pos_y, pv.big_y, pv.q_y);
                if (pv.zero)
                begin
                    sd.fx  = '0;
                    sd.fy  = '0;
                    sd.sat = 1'b0;
                end
                else
                begin
                    sd.fx  = ex.force_val;
                    sd.fy  = ey.force_val;
                    sd.sat = ex.sat || ey.sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= '0;
        end
        else if (stage_en)
        begin
            pipe_valid_reg <= {pipe_valid_reg[N_STAGE-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            for (int k = 0; k < N_STAGE; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign m_axis_tvalid = pipe_valid_reg[ST_EM];
    assign m_axis_tdata  = {pipe_reg[ST_EM].fy, pipe_reg[ST_EM].fx};
    assign m_axis_tuser  = {pipe_reg[ST_EM].sat, pipe_reg[ST_EM].coinc};

`ifndef ASSERT_OFF
    a_coinc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
        else $error("coincident word carries a force");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            pipe_reg[ST_EM].fx == LIM_POS || pipe_reg[ST_EM].fx == LIM_NEG ||
            pipe_reg[ST_EM].fy == LIM_POS || pipe_reg[ST_EM].fy == LIM_NEG)
        else $error("saturated flag without a clipped component");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_en |=> $stable(pipe_valid_reg))
        else $error("pipeline moved during a stall");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pipe_valid_reg[0]) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("entry stage filled without an accepted word");
`endif

endmodule
